### design/cse_pkg.sv
package cse_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int CFG_W     = 12;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 11;
    localparam int ACC_W     = 12;
    localparam int N_DIR     = 8;
    localparam int N_TAP     = 9;
    localparam int MIN_DIM   = 3;
    localparam int EDGE_MAX  = 255;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } t_reg_index;

    typedef logic [PIX_W-1:0]        t_pixel;
    typedef t_pixel                  t_window [N_TAP];
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [2:0]       t_coef;

    // window taps row major: top row 0..2, middle 3..5, bottom 6..8
    localparam t_coef KERNELS [N_DIR][N_TAP] = '{
        '{-3'sd1, -3'sd2, -3'sd1,  3'sd0,  3'sd0,  3'sd0,  3'sd1,  3'sd2,  3'sd1},
        '{ 3'sd0, -3'sd1, -3'sd2,  3'sd1,  3'sd0, -3'sd1,  3'sd2,  3'sd1,  3'sd0},
        '{ 3'sd1,  3'sd0, -3'sd1,  3'sd2,  3'sd0, -3'sd2,  3'sd1,  3'sd0, -3'sd1},
        '{ 3'sd2,  3'sd1,  3'sd0,  3'sd1,  3'sd0, -3'sd1,  3'sd0, -3'sd1, -3'sd2},
        '{ 3'sd1,  3'sd2,  3'sd1,  3'sd0,  3'sd0,  3'sd0, -3'sd1, -3'sd2, -3'sd1},
        '{ 3'sd0,  3'sd1,  3'sd2, -3'sd1,  3'sd0,  3'sd1, -3'sd2, -3'sd1,  3'sd0},
        '{-3'sd1,  3'sd0,  3'sd1, -3'sd2,  3'sd0,  3'sd2, -3'sd1,  3'sd0,  3'sd1},
        '{-3'sd2, -3'sd1,  3'sd0, -3'sd1,  3'sd0,  3'sd1,  3'sd0,  3'sd1,  3'sd2}
    };

    // constant coefficients, so this folds into a small shift-add tree
    function automatic t_sum compass_sum(input t_window win, input int dir);
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] coef;
        logic signed [ACC_W-1:0] pix;
        acc = '0;
        for (int t = 0; t < N_TAP; t++) begin
            coef = ACC_W'(KERNELS[dir][t]);
            pix  = ACC_W'({1'b0, win[t]});
            acc  = acc + coef * pix;
        end
        return SUM_W'(acc);
    endfunction

endpackage

### design/compass_sobel_edge_detector_unit.sv
// compass sobel edge detector
// s channel: one 8-bit gray pixel per word, raster order, frame after frame.
// m channel: one edge word per interior pixel (border rows and columns give
// nothing); tdata is the largest of eight compass sobel responses clamped to
// 0..255, tlast marks the last interior pixel of the frame.
// cfg channel: index 0 frame width (3..2048), index 1 frame height (3..4095),
// out of range values clamp; an index 0 or 1 write restarts at row 0 col 0.
// write only while no pixel is in flight; the cfg channel is always ready.
// throughput: one pixel per clock unless stalled. each pixel does one
// read and one write of the single line memory (2048 x 16, both stored
// rows per column). path from pixel accept to o_m_tvalid: memory read,
// window, direction sums, then the output register that max and clamp feed.
// stall: four pipeline stages keep taking pixels while a result waits;
// o_s_tready drops only when all of them are full.
// reset: 640 x 480, counters and pipeline valids cleared; line memory is not
// cleared, its stale contents only reach border windows that give no result.
module compass_sobel_edge_detector_unit
    import cse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] gray_pixel
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] edge_value
    output logic             o_m_tlast,   // frame_done
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [COL_W-1:0] r_w_last;
    logic [ROW_W-1:0] r_h_last;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;

    logic             r_v1;
    logic             r_s1_prod;
    logic             r_s1_done;
    logic [COL_W-1:0] r_s1_col;
    t_pixel           r_s1_pix;

    t_window r_win;
    logic    r_wv;
    logic    r_wdone;

    logic r_v2;
    logic r_done2;
    t_sum r_sums [N_DIR];

    logic   r_ov;
    t_pixel r_edge;
    logic   r_olast;

    logic s_accept, cfg_write;
    logic en3, en2, win_en, s1_adv;
    logic prod, done;
    t_sum best;
    t_pixel n_edge;
    logic [COL_W-1:0] n_w_last;
    logic [ROW_W-1:0] n_h_last;

    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    assign en3    = !r_ov || i_m_tready;
    assign en2    = !r_v2 || en3;
    assign win_en = !r_wv || en2;
    assign s1_adv = r_v1 && win_en;

    assign o_s_tready = !r_v1 || win_en;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign prod = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign done = (r_row == r_h_last) && (r_col == r_w_last);

    // clamp the new width / height to their last index
    always_comb begin
        n_w_last = r_w_last;
        n_h_last = r_h_last;
        if (int'(i_cfg_data) < MIN_DIM) begin
            n_w_last = COL_W'(MIN_DIM - 1);
            n_h_last = ROW_W'(MIN_DIM - 1);
        end else begin
            if (int'(i_cfg_data) > MAX_WIDTH) begin
                n_w_last = COL_W'(MAX_WIDTH - 1);
            end else begin
                n_w_last = COL_W'(i_cfg_data - CFG_W'(1));
            end
            n_h_last = ROW_W'(i_cfg_data - CFG_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= COL_W'(WIDTH_RESET - 1);
            r_h_last <= ROW_W'(HEIGHT_RESET - 1);
            r_col    <= '0;
            r_row    <= '0;
        end else if (cfg_write) begin
            if (t_reg_index'(i_cfg_index) == REG_FRAME_WIDTH) begin
                r_w_last <= n_w_last;
                r_col    <= '0;
                r_row    <= '0;
            end else if (t_reg_index'(i_cfg_index) == REG_FRAME_HEIGHT) begin
                r_h_last <= n_h_last;
                r_col    <= '0;
                r_row    <= '0;
            end
        end else if (s_accept) begin
            if (r_col == r_w_last) begin
                r_col <= '0;
                r_row <= (r_row == r_h_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // line memory word: [15:8] row two above, [7:0] row just above
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_rd <= r_line_mem[r_col];
        end
        if (s1_adv) begin
            r_line_mem[r_s1_col] <= {r_rd[PIX_W-1:0], r_s1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_s_tready) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_prod <= prod;
            r_s1_done <= done;
            r_s1_col  <= r_col;
            r_s1_pix  <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv    <= 1'b0;
            r_wdone <= 1'b0;
            for (int i = 0; i < N_TAP; i++) begin
                r_win[i] <= '0;
            end
        end else if (win_en) begin
            r_wv    <= r_v1 && r_s1_prod;
            r_wdone <= r_s1_done;
            if (r_v1) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= r_rd[2*PIX_W-1:PIX_W];
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= r_rd[PIX_W-1:0];
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= r_s1_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_done2 <= r_wdone;
            for (int k = 0; k < N_DIR; k++) begin
                r_sums[k] <= compass_sum(r_win, k);
            end
        end
    end

    // strongest direction, floored at zero and clamped to a byte
    always_comb begin
        best = '0;
        for (int k = 0; k < N_DIR; k++) begin
            if (r_sums[k] > best) begin
                best = r_sums[k];
            end
        end
        n_edge = (best > t_sum'(EDGE_MAX)) ? PIX_W'(EDGE_MAX) : best[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en3) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_edge  <= n_edge;
            r_olast <= r_done2;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_edge;
    assign o_m_tlast  = r_olast;

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_w_last)
        else $error("column counter beyond frame width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_h_last)
        else $error("row counter beyond frame height");

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !cfg_write && r_col == r_w_last) |=> (r_col == '0))
        else $error("column counter did not wrap at end of row");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_v1 && r_wv && r_v2 && r_ov && !i_m_tready))
        else $error("input stalled while pipeline has room");
`endif

endmodule
